// File: rtl/core/sitoa_pkg.sv
// Shared constants, types and helpers for the signed integer to decimal text converter.
package sitoa_pkg;

  // Default width of the integer that is converted.
  localparam int VALUE_BITS_DEF = 32;

  // ASCII codes, cut to the 6 bits that the result carries.
  localparam logic [5:0] CHAR_MINUS = 6'd45;
  localparam logic [5:0] CHAR_ZERO  = 6'd48;

  // Decimal digits needed for any unsigned value of the given width.
  // 1233/4096 is just below log10(2), which is close enough for 8 to 64 bits.
  function automatic int digits_for(input int bits);
    return (bits * 1233) / 4096 + 1;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // take the input request and start a conversion
    logic shift;       // one shift-and-add-3 step
    logic skip;        // drop a leading zero digit
    logic emit_sign;   // put the minus sign in the output register
    logic emit_digit;  // put the top digit in the output register
  } sitoa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bit_last;    // the current shift step is the final one
    logic top_zero;    // top digit is zero and more digits follow
    logic last_digit;  // only one digit is left to send
    logic neg;         // the value being converted is negative
    logic out_free;    // the output register can take a character
  } sitoa_status_t;

endpackage

// File: rtl/core/sitoa_dp.sv
// Datapath: magnitude, BCD shift register, counters and the output register.
module sitoa_dp #(
  parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sitoa_pkg::sitoa_cmd_t   cmd,
  output sitoa_pkg::sitoa_status_t status,
  input  logic [VALUE_BITS-1:0]   value,
  output logic [5:0]              ascii_char,
  output logic                    is_last,
  output logic                    out_valid,
  input  logic                    out_ready
);
  import sitoa_pkg::*;

  localparam int ND   = digits_for(VALUE_BITS);
  localparam int BW   = ND * 4;
  localparam int BC_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int DC_W = $clog2(ND + 1);

  logic [VALUE_BITS-1:0] mag_r;
  logic                  neg_r;
  logic [BW-1:0]         bcd_r;
  logic [BC_W-1:0]       bitcnt_r;
  logic [DC_W-1:0]       dcnt_r;
  logic [5:0]            char_r;
  logic                  last_r;
  logic                  valid_r;

  logic [BW-1:0]         bcd_adj;
  logic [VALUE_BITS-1:0] mag_in;
  logic [3:0]            top_digit;

  // Add 3 to every digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  // Magnitude of the incoming value; the most negative value maps to its exact magnitude.
  assign mag_in    = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
  assign top_digit = bcd_r[BW-1 -: 4];

  // Conversion registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r    <= mag_in;
      neg_r    <= value[VALUE_BITS-1];
      bcd_r    <= '0;
      bitcnt_r <= BC_W'(VALUE_BITS - 1);
      dcnt_r   <= DC_W'(ND);
    end else if (cmd.shift) begin
      bcd_r    <= {bcd_adj[BW-2:0], mag_r[VALUE_BITS-1]};
      mag_r    <= mag_r << 1;
      bitcnt_r <= bitcnt_r - 1'b1;
    end else if (cmd.skip || cmd.emit_digit) begin
      bcd_r  <= bcd_r << 4;
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  // Output register: payload without reset, valid flag cleared by reset.
  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      char_r <= CHAR_MINUS;
      last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      char_r <= CHAR_ZERO + {2'b00, top_digit};
      last_r <= (dcnt_r == DC_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Status towards the controller.
  always_comb begin
    status.bit_last   = (bitcnt_r == '0);
    status.top_zero   = (top_digit == 4'd0) && (dcnt_r > DC_W'(1));
    status.last_digit = (dcnt_r == DC_W'(1));
    status.neg        = neg_r;
    status.out_free   = !valid_r || out_ready;
  end

  assign ascii_char = char_r;
  assign is_last    = last_r;
  assign out_valid  = valid_r;

endmodule

// File: rtl/core/sitoa_ctrl.sv
// Controller: sequences loading, conversion, zero skipping and character output.
module sitoa_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  sitoa_pkg::sitoa_status_t status,
  output sitoa_pkg::sitoa_cmd_t    cmd
);
  import sitoa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_DIGITS
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Commands and next state from the current state and datapath status.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift = 1'b1;
        if (status.bit_last) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (status.top_zero) begin
          cmd.skip = 1'b1;
        end else if (status.neg) begin
          state_nxt = S_SIGN;
        end else begin
          state_nxt = S_DIGITS;
        end
      end
      S_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.last_digit) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII text converter.
//
// Input stream: in_tdata carries one two's complement integer of VALUE_BITS
// bits per request; padding bits above it are ignored. Output stream: one
// ASCII character per request in reading order, a minus sign first for a
// negative value, then the digits without leading zeros; out_tlast marks
// the final character of each value.
// Timing: a value is converted by a shift-and-add-3 loop, one magnitude bit
// per cycle. Leading zero digits are then dropped one per cycle, and
// characters leave one per cycle while the receiver accepts them.
// Only one value is worked on at a time; in_tready is high while idle,
// which includes the time the final character still waits in the output
// register. A stalled receiver holds the current character and pauses the
// output sequence. Reset returns to idle and drops any pending character.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]   in_tdata,   // [VALUE_BITS-1:0] value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // [5:0] ascii_char
  output logic                              out_tlast   // is_last
);
  import sitoa_pkg::*;

  sitoa_cmd_t    cmd;
  sitoa_status_t status;
  logic [5:0]    ascii_char;

  // Sequencing.
  sitoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Conversion and output storage.
  sitoa_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .value      (in_tdata[VALUE_BITS-1:0]),
    .ascii_char (ascii_char),
    .is_last    (out_tlast),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready)
  );

  assign out_tdata = {2'b00, ascii_char};

endmodule
